FILE: rtl/all_pairs_shortest_path_top_assert.svh
// Assertion macros for the all-pairs shortest path block.
// Included by rtl/all_pairs_shortest_path_top.sv; no other dependencies.
`ifndef ALL_PAIRS_SHORTEST_PATH_TOP_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define APSP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("apsp assertion failed");

`define APSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apsp assertion failed");

`else

`define APSP_ASSERT(lbl, clk, rst_n, prop)

`define APSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/apsp_pkg.sv
// Package for the all-pairs shortest path block: field widths, defaults,
// request mode codes and the controller state type. No dependencies.
package apsp_pkg;

    localparam int MAX_NODES_DEF = 128;
    localparam int DIST_BITS_DEF = 24;

    localparam int MODE_W = 2;
    localparam int NODE_W = 7;
    localparam int COST_W = 16;
    localparam int OUT_W  = 24;
    localparam int CFG_W  = 8;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_INS_RD,
        S_INS_WR1,
        S_INS_WR2,
        S_ROW,
        S_COL,
        S_DRAIN,
        S_Q_RD,
        S_Q_OUT
    } t_state;

endpackage

FILE: rtl/all_pairs_shortest_path_top.sv
// All-pairs shortest path block: distance matrix in one RAM, Floyd-Warshall closure.
// Depends on apsp_pkg, apsp_ram and all_pairs_shortest_path_top_assert.svh.
//
// A clear request sweeps the whole matrix RAM, one entry a cycle. An insert
// request reads both entries, then writes the cost back to each one that it
// lowers. A query first runs, if it is the first query after a clear, an insert
// or a num_nodes write, the closure over the n nodes in use, whose relax updates
// go through the single RAM write port, then reads its entry into the output
// register. Requests are taken one at a time; a finished result waits in the
// output register while the next request is accepted.
module all_pairs_shortest_path_top
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int DIST_BITS = DIST_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic [COST_W-1:0] i_edge_cost,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OUT_W-1:0]  o_distance,
    output logic              o_unreachable,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

`include "all_pairs_shortest_path_top_assert.svh"

    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int EXT_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int COST_WIDE = (COST_W > DIST_BITS) ? COST_W : DIST_BITS;
    localparam int OUT_WIDE  = (OUT_W > DIST_BITS) ? OUT_W : DIST_BITS;

    localparam logic [DIST_BITS-1:0] DIST_INF = '1;
    localparam logic [EXT_W-1:0]     MAX_EXT  = EXT_W'(MAX_NODES);

    t_state                 r_state, n_state;
    logic                   r_closure_done;
    logic [CFG_W-1:0]       r_num_nodes;
    logic [IDX_W-1:0]       r_a, r_b;
    logic                   r_ab_ok;
    logic [DIST_BITS-1:0]   r_cost;
    logic [IDX_W-1:0]       r_k, r_i, r_j;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic                   r_row_q;
    logic [DIST_BITS-1:0]   r_dik;
    logic                   r_p1_v, r_p2_v;
    logic [ADDR_W-1:0]      r_p1_addr, r_p2_addr;
    logic [DIST_BITS-1:0]   r_p2_sum, r_p2_old;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_dist;
    logic                   r_out_unr;

    logic                   w_in_acc, w_cfg_acc, w_out_acc, w_out_load;
    logic [EXT_W-1:0]       w_cfg_ext, w_n_use, w_n_last;
    logic [EXT_W-1:0]       w_a_ext, w_b_ext;
    logic                   w_a_ok, w_b_ok;
    logic [COST_WIDE-1:0]   w_cost_wide;
    logic [DIST_BITS-1:0]   w_cost_sat;
    logic                   w_j_last, w_i_last, w_k_last, w_pipe_empty;
    logic [IDX_W-1:0]       w_clr_row, w_clr_col;
    logic [DIST_BITS:0]     w_sum_full;
    logic [DIST_BITS-1:0]   w_sum_sat;
    logic [DIST_BITS-1:0]   w_q_dist;
    logic [OUT_WIDE-1:0]    w_q_wide;

    logic                   w_we, w_re_a, w_re_b;
    logic [ADDR_W-1:0]      w_waddr, w_raddr_a, w_raddr_b;
    logic [DIST_BITS-1:0]   w_wdata, w_rdata_a, w_rdata_b;

    apsp_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_matrix (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re_a    (w_re_a),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_re_b    (w_re_b),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    assign o_stall       = (r_state != S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_distance    = r_out_dist;
    assign o_unreachable = r_out_unr;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_acc  = r_out_valid && !i_stall;
    assign w_out_load = (r_state == S_Q_OUT) && (!r_out_valid || !i_stall);

    assign w_cfg_ext = EXT_W'(r_num_nodes);
    assign w_n_use   = (w_cfg_ext > MAX_EXT) ? MAX_EXT : w_cfg_ext;
    assign w_n_last  = w_n_use - EXT_W'(1);

    assign w_a_ext = EXT_W'(i_node_a);
    assign w_b_ext = EXT_W'(i_node_b);
    assign w_a_ok  = (w_a_ext < MAX_EXT);
    assign w_b_ok  = (w_b_ext < MAX_EXT);

    assign w_cost_wide = COST_WIDE'(i_edge_cost);
    assign w_cost_sat  = (w_cost_wide > COST_WIDE'(DIST_INF)) ? DIST_INF
                                                              : w_cost_wide[DIST_BITS-1:0];

    assign w_j_last     = (EXT_W'(r_j) == w_n_last);
    assign w_i_last     = (EXT_W'(r_i) == w_n_last);
    assign w_k_last     = (EXT_W'(r_k) == w_n_last);
    assign w_pipe_empty = !r_p1_v && !r_p2_v;

    assign w_clr_row = r_clr_addr[ADDR_W-1:IDX_W];
    assign w_clr_col = r_clr_addr[IDX_W-1:0];

    assign w_sum_full = {1'b0, r_dik} + {1'b0, w_rdata_a};
    assign w_sum_sat  = (w_sum_full > {1'b0, DIST_INF}) ? DIST_INF
                                                        : w_sum_full[DIST_BITS-1:0];

    assign w_q_dist = r_ab_ok ? w_rdata_a : DIST_INF;
    assign w_q_wide = OUT_WIDE'(w_q_dist);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        MODE_INSERT: begin
                            n_state = (w_a_ok && w_b_ok) ? S_INS_RD : S_IDLE;
                        end
                        MODE_QUERY: begin
                            n_state = (r_closure_done || (w_n_use == '0)) ? S_Q_RD : S_ROW;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_INS_RD: begin
                n_state = S_INS_WR1;
            end
            S_INS_WR1: begin
                n_state = S_INS_WR2;
            end
            S_INS_WR2: begin
                n_state = S_IDLE;
            end
            S_ROW: begin
                n_state = S_COL;
            end
            S_COL: begin
                if (w_j_last) begin
                    n_state = w_i_last ? S_DRAIN : S_ROW;
                end
            end
            S_DRAIN: begin
                if (w_pipe_empty) begin
                    n_state = w_k_last ? S_Q_RD : S_ROW;
                end
            end
            S_Q_RD: begin
                n_state = S_Q_OUT;
            end
            S_Q_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        w_re_a    = 1'b0;
        w_raddr_a = '0;
        w_re_b    = 1'b0;
        w_raddr_b = '0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = ((w_clr_row == w_clr_col) && (EXT_W'(w_clr_row) < w_n_use))
                        ? '0 : DIST_INF;
            end
            S_INS_RD: begin
                w_re_a    = 1'b1;
                w_raddr_a = {r_a, r_b};
                w_re_b    = 1'b1;
                w_raddr_b = {r_b, r_a};
            end
            S_INS_WR1: begin
                w_we    = (r_cost < w_rdata_a);
                w_waddr = {r_a, r_b};
                w_wdata = r_cost;
            end
            S_INS_WR2: begin
                w_we    = (r_cost < w_rdata_b);
                w_waddr = {r_b, r_a};
                w_wdata = r_cost;
            end
            S_ROW: begin
                w_re_a    = 1'b1;
                w_raddr_a = {r_i, r_k};
            end
            S_COL: begin
                w_re_a    = 1'b1;
                w_raddr_a = {r_k, r_j};
                w_re_b    = 1'b1;
                w_raddr_b = {r_i, r_j};
            end
            S_Q_RD: begin
                w_re_a    = 1'b1;
                w_raddr_a = {r_a, r_b};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        // relax step write-back
        if (r_p2_v && (r_p2_sum < r_p2_old)) begin
            w_we    = 1'b1;
            w_waddr = r_p2_addr;
            w_wdata = r_p2_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_closure_done <= 1'b0;
            r_num_nodes    <= CFG_W'(1);
            r_k            <= '0;
            r_i            <= '0;
            r_j            <= '0;
            r_clr_addr     <= '0;
            r_row_q        <= 1'b0;
            r_p1_v         <= 1'b0;
            r_p2_v         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row_q <= (r_state == S_ROW);
            r_p1_v  <= (r_state == S_COL);
            r_p2_v  <= r_p1_v;

            if (w_in_acc) begin
                r_k        <= '0;
                r_i        <= '0;
                r_j        <= '0;
                r_clr_addr <= '0;
            end

            if (w_cfg_acc) begin
                r_closure_done <= 1'b0;
            end else if (w_in_acc && ((i_mode == MODE_CLEAR)
                         || ((i_mode == MODE_INSERT) && w_a_ok && w_b_ok))) begin
                r_closure_done <= 1'b0;
            end else if ((w_in_acc && (i_mode == MODE_QUERY) && (w_n_use == '0))
                         || ((r_state == S_DRAIN) && w_pipe_empty && w_k_last)) begin
                r_closure_done <= 1'b1;
            end

            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end

            if (r_state == S_COL) begin
                r_j <= w_j_last ? '0 : r_j + IDX_W'(1);
                if (w_j_last) begin
                    r_i <= w_i_last ? '0 : r_i + IDX_W'(1);
                end
            end

            if ((r_state == S_DRAIN) && w_pipe_empty) begin
                r_i <= '0;
                r_k <= w_k_last ? '0 : r_k + IDX_W'(1);
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end

            if (w_cfg_acc) begin
                r_num_nodes <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a     <= w_a_ext[IDX_W-1:0];
            r_b     <= w_b_ext[IDX_W-1:0];
            r_ab_ok <= w_a_ok && w_b_ok;
            r_cost  <= w_cost_sat;
        end
        if (r_row_q) begin
            r_dik <= w_rdata_a;
        end
        r_p1_addr <= {r_i, r_j};
        r_p2_addr <= r_p1_addr;
        r_p2_sum  <= w_sum_sat;
        r_p2_old  <= w_rdata_b;
        if (w_out_load) begin
            r_out_dist <= w_q_wide[OUT_W-1:0];
            r_out_unr  <= (w_q_dist == DIST_INF);
        end
    end

    `APSP_ASSERT_IMPLY(a_query_after_closure, i_clk, i_rst_n, r_state == S_Q_RD, r_closure_done)
    `APSP_ASSERT_IMPLY(a_relax_in_closure, i_clk, i_rst_n, r_p2_v, (r_state == S_COL) || (r_state == S_ROW) || (r_state == S_DRAIN))
    `APSP_ASSERT_IMPLY(a_result_from_query, i_clk, i_rst_n, $rose(o_valid), $past(r_state == S_Q_OUT))
    `APSP_ASSERT_IMPLY(a_col_in_range, i_clk, i_rst_n, r_state == S_COL, EXT_W'(r_j) < w_n_use)
    `APSP_ASSERT(a_no_write_idle, i_clk, i_rst_n, !((r_state == S_IDLE) && w_we))

endmodule

FILE: rtl/apsp_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// Read data holds while its read enable is low. No dependencies.
module apsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

FILE: tb/sv/tb_all_pairs_shortest_path_top.sv
// Self-checking testbench for all_pairs_shortest_path_top: directed and random graphs,
// with an in-bench distance matrix and closure that predict every query answer.
// Depends on apsp_pkg and the RTL of all_pairs_shortest_path_top.
module tb_all_pairs_shortest_path_top;
    timeunit 1ns;
    timeprecision 1ps;

    import apsp_pkg::*;

    localparam int N_MAX          = MAX_NODES_DEF;
    localparam int CLEAR_CYCLES   = N_MAX * N_MAX + 64;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int TARGET_ITEMS   = 550;
    localparam int CALM_ITEMS     = 90;

    localparam logic [OUT_W-1:0]  DIST_INF    = '1;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0] distance;
        logic             unreachable;
    } t_dist_answer;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic [MODE_W-1:0] i_mode        = '0;
    logic [NODE_W-1:0] i_node_a      = '0;
    logic [NODE_W-1:0] i_node_b      = '0;
    logic [COST_W-1:0] i_edge_cost   = '0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    logic [OUT_W-1:0]  o_distance;
    logic              o_unreachable;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data    = '0;

    logic [OUT_W-1:0] path_len [N_MAX][N_MAX];
    logic             paths_closed = 1'b0;
    logic [CFG_W-1:0] nodes_cfg    = 8'd1;
    t_dist_answer     answers_due[$];

    bit          idle_on       = 1'b1;
    int unsigned items_sent    = 0;
    int unsigned settle_cycles = 0;
    int unsigned mismatches    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned stall_left    = 0;

    all_pairs_shortest_path_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_edge_cost   (i_edge_cost),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_distance    (o_distance),
        .o_unreachable (o_unreachable),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic void apply_request(input logic [MODE_W-1:0] mode,
                                          input logic [NODE_W-1:0] a,
                                          input logic [NODE_W-1:0] b,
                                          input logic [COST_W-1:0] cost);
        int unsigned      n;
        logic [OUT_W:0]   via;
        logic [OUT_W-1:0] len;
        n = (nodes_cfg > N_MAX) ? N_MAX : nodes_cfg;
        case (mode)
            MODE_CLEAR: begin
                for (int r = 0; r < N_MAX; r++)
                    for (int c = 0; c < N_MAX; c++)
                        path_len[r][c] = (r == c && r < n) ? '0 : DIST_INF;
                paths_closed = 1'b0;
            end
            MODE_INSERT: begin
                if (OUT_W'(cost) < path_len[a][b]) path_len[a][b] = OUT_W'(cost);
                if (OUT_W'(cost) < path_len[b][a]) path_len[b][a] = OUT_W'(cost);
                paths_closed = 1'b0;
            end
            MODE_QUERY: begin
                if (!paths_closed) begin
                    for (int k = 0; k < n; k++)
                        for (int r = 0; r < n; r++)
                            for (int c = 0; c < n; c++) begin
                                via = {1'b0, path_len[r][k]} + {1'b0, path_len[k][c]};
                                if (via > {1'b0, DIST_INF}) via = {1'b0, DIST_INF};
                                if (via[OUT_W-1:0] < path_len[r][c])
                                    path_len[r][c] = via[OUT_W-1:0];
                            end
                    paths_closed = 1'b1;
                end
                len = path_len[a][b];
                answers_due.push_back('{len, len == DIST_INF});
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        mismatches++;
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [NODE_W-1:0] a,
                                input logic [NODE_W-1:0] b, input logic [COST_W-1:0] cost);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_node_a    <= a;
        i_node_b    <= b;
        i_edge_cost <= cost;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_request(mode, a, b, cost);
        if (mode != MODE_UNUSED) items_sent++;
        settle_cycles = (mode == MODE_CLEAR) ? CLEAR_CYCLES : 16;
    endtask

    // hold the sender until every pending answer is back and the block has gone idle
    task automatic drain_answers();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
        repeat (settle_cycles) @(posedge i_clk);
        settle_cycles = 0;
    endtask

    task automatic write_node_count(input logic [CFG_W-1:0] count);
        drain_answers();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        nodes_cfg    = count;
        paths_closed = 1'b0;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_graph();
        write_node_count(8'd4);
        send_request(MODE_CLEAR, 7'd0, 7'd0, 16'd0);
        send_request(MODE_QUERY, 7'd0, 7'd0, 16'd0);
        send_request(MODE_QUERY, 7'd3, 7'd0, 16'd0);
        send_request(MODE_QUERY, 7'd127, 7'd127, 16'hFFFF);
        send_request(MODE_UNUSED, 7'd127, 7'd127, 16'hFFFF);
    endtask

    task automatic test_edge_folding();
        send_request(MODE_INSERT, 7'd0, 7'd1, 16'd0);
        send_request(MODE_INSERT, 7'd1, 7'd2, 16'hFFFF);
        send_request(MODE_INSERT, 7'd2, 7'd3, 16'h1234);
        send_request(MODE_INSERT, 7'd1, 7'd2, 16'd5);
        send_request(MODE_INSERT, 7'd3, 7'd3, 16'd7);
        send_request(MODE_INSERT, 7'd127, 7'd126, 16'hFFFF);
        send_request(MODE_QUERY, 7'd0, 7'd3, 16'd0);
        drain_answers();
        send_request(MODE_QUERY, 7'd3, 7'd0, 16'd0);
        send_request(MODE_QUERY, 7'd127, 7'd126, 16'd0);
        send_request(MODE_QUERY, 7'd2, 7'd2, 16'd0);
        send_request(MODE_QUERY, 7'd0, 7'd126, 16'd0);
    endtask

    task automatic test_node_count_zero();
        write_node_count(8'd0);
        send_request(MODE_CLEAR, 7'd0, 7'd0, 16'd0);
        send_request(MODE_INSERT, 7'd5, 7'd6, 16'd9);
        send_request(MODE_QUERY, 7'd5, 7'd6, 16'd0);
        send_request(MODE_QUERY, 7'd0, 7'd0, 16'd0);
    endtask

    task automatic test_node_count_saturation();
        write_node_count(8'd255);
        send_request(MODE_CLEAR, 7'd0, 7'd0, 16'd0);
        write_node_count(8'd3);
        send_request(MODE_INSERT, 7'd100, 7'd101, 16'd1);
        send_request(MODE_QUERY, 7'd127, 7'd127, 16'd0);
        send_request(MODE_QUERY, 7'd101, 7'd100, 16'd0);
    endtask

    task automatic test_random_graphs();
        int unsigned       n;
        int unsigned       pick;
        int unsigned       len;
        int unsigned       roll;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic [COST_W-1:0] cost;
        while (items_sent < TARGET_ITEMS) begin
            idle_on = (items_sent + CALM_ITEMS < TARGET_ITEMS);
            pick = $urandom_range(0, 19);
            if (pick == 0) n = 1;
            else if (pick == 1) n = 0;
            else if (pick == 2) n = $urandom_range(10, 16);
            else n = $urandom_range(2, 8);
            if (pick == 3) begin
                write_node_count($urandom_range(0, 1) ? 8'd128 : 8'($urandom_range(129, 255)));
                send_request(MODE_CLEAR, 7'($urandom), 7'($urandom), 16'($urandom));
                write_node_count(8'(n));
            end else begin
                write_node_count(8'(n));
                send_request(MODE_CLEAR, 7'($urandom), 7'($urandom), 16'($urandom));
            end
            len = $urandom_range(14, 26);
            for (int k = 0; k < len; k++) begin
                roll = $urandom_range(0, 99);
                a = (n > 0 && $urandom_range(0, 99) < 85) ? 7'($urandom_range(0, n - 1))
                                                          : 7'($urandom);
                b = (n > 0 && $urandom_range(0, 99) < 85) ? 7'($urandom_range(0, n - 1))
                                                          : 7'($urandom);
                case ($urandom_range(0, 9))
                    0:       cost = 16'hFFFF;
                    1:       cost = 16'd0;
                    2, 3, 4,
                    5:       cost = 16'($urandom_range(1, 50));
                    default: cost = 16'($urandom);
                endcase
                if (roll < 45) begin
                    send_request(MODE_INSERT, a, b, cost);
                end else if (roll < 95) begin
                    send_request(MODE_QUERY, a, b, cost);
                end else if (roll < 97) begin
                    send_request(MODE_UNUSED, a, b, cost);
                end else begin
                    n = $urandom_range(1, 8);
                    write_node_count(8'(n));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_stall    <= 1'b1;
        end else begin
            i_stall    <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_answers
        t_dist_answer due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result with no query pending", o_distance, '0);
            end else begin
                due = answers_due.pop_front();
                if (o_distance !== due.distance)
                    report_mismatch("distance", o_distance, due.distance);
                if (o_unreachable !== due.unreachable)
                    report_mismatch("unreachable", OUT_W'(o_unreachable),
                                    OUT_W'(due.unreachable));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** all_pairs_shortest_path_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_graph();
        test_edge_folding();
        test_node_count_zero();
        test_node_count_saturation();
        test_random_graphs();
        drain_answers();
        repeat (32) @(posedge i_clk);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("** all_pairs_shortest_path_top: PASSED **");
        end else begin
            $display("** all_pairs_shortest_path_top: FAILED **");
        end
        $finish;
    end

endmodule
